@@ hw/rtl/cqr_pkg.sv @@
package cqr_pkg;

  localparam int MAX_ENTRIES_DEF = 16;

  localparam int CHAN_W  = 8;
  localparam int BUSY_W  = 18;
  localparam int VISIT_W = 8;
  localparam int FLOOR_W = 8;
  localparam int PCT_W   = 7;
  localparam int RCNT_W  = 5;
  localparam int STAT_W  = 2;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 18;

  localparam logic [VISIT_W-1:0] VISIT_MAX = '1;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_HOME_CHANNEL = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANK_VISITS  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEAVE_MARGIN = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LEVEL  = 4'd3;

  // Item kinds.
  localparam logic CMD_REGISTER = 1'b0;
  localparam logic CMD_SAMPLE   = 1'b1;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_DUPLICATE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STAT_W-1:0] ST_UNKNOWN   = 2'd3;

  // One table entry as held in the memory.
  typedef struct packed {
    logic [CHAN_W-1:0]         channel;
    logic [BUSY_W-1:0]         busy;
    logic [VISIT_W-1:0]        visits;
    logic                      floor_seen;
    logic signed [FLOOR_W-1:0] floor_lvl;
    logic                      pct_seen;
    logic [PCT_W-1:0]          pct;
  } rec_t;

  // Port controls of the entry store.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

endpackage

@@ hw/rtl/cqr_store.sv @@
module cqr_store import cqr_pkg::*; #(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
  localparam int AW = $clog2(MAX_ENTRIES)
) (
  input  logic          clk,
  input  logic          rst,
  input  mem_ctl_t      ctl,
  input  logic [AW-1:0] rd_addr,
  input  logic [AW-1:0] wr_addr,
  input  rec_t          wr_rec,
  output rec_t          rd_rec
);

  rec_t mem [MAX_ENTRIES];
  rec_t rd_raw;
  logic rd_zero;
  // The home entry starts with clear statistics; the others are always
  // written when they join the table.
  logic home_init;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_rec;
    end
    if (ctl.rd_en) begin
      rd_raw <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      home_init <= 1'b0;
      rd_zero   <= 1'b0;
    end else begin
      if (ctl.wr_en && wr_addr == '0) begin
        home_init <= 1'b1;
      end
      if (ctl.rd_en) begin
        rd_zero <= (rd_addr == '0) && !home_init;
      end
    end
  end

  always_comb begin
    rd_rec = rd_raw;
    if (rd_zero) begin
      rd_rec            = '0;
      rd_rec.channel    = rd_raw.channel;
    end
  end

endmodule

@@ hw/rtl/channel_quality_ranker.sv @@
// Channel quality ranker.
// Items arrive on the s_ stream: tuser carries the kind (register a
// candidate or add a sample), tdata the channel and the sample counts.
// Every accepted beat yields exactly one result beat on the m_ stream with
// the proposed channel, the number of ranked entries and a status in tuser.
// Registers are written through cfg_we / cfg_index / cfg_data; the user must
// write them only while no item is in flight, as the block does not enforce it.
// All entry state sits in one single-port-read memory. An item first scans
// the table for its channel (stops at the first match), writes the new or
// updated entry where there is one, then scans every entry again to rank
// them, as the memory gives one read per cycle. A new beat is taken only
// once the result of the last one has gone into the output register.
// Reset leaves only the home entry in the table with clear statistics and
// loads the register defaults. A stalled receiver holds the result in the
// output register; the next beat is still accepted, and its result waits
// until the earlier one has been taken.
module channel_quality_ranker import cqr_pkg::*; #(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // channel[7:0], cca_count[23:8], own_count[39:24], false_alarm_count[55:40],
  // foreign_count[71:56], floor_ok[72], floor_level[80:73], pct_ok[81],
  // busy_percent[88:82], zero pad[95:89]
  input  logic [95:0]           s_tdata,
  // cmd[0]
  input  logic                  s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // proposed_channel[7:0], ranked_count[12:8], zero pad[15:13]
  output logic [15:0]           m_tdata,
  // status[1:0]
  output logic [STAT_W-1:0]     m_tuser
);

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_FIND, ST_UPDATE, ST_RSTART, ST_RANK, ST_DECIDE
  } state_t;

  state_t state;

  // Configuration.
  logic [CHAN_W-1:0]     home_channel;
  logic [VISIT_W-1:0]    rank_visits;
  logic [BUSY_W-1:0]     leave_margin;
  logic [PCT_W-1:0]      block_level;

  // Item held for the duration of its work.
  logic                  it_cmd;
  logic [CHAN_W-1:0]     it_chan;
  logic [15:0]           it_cca;
  logic [15:0]           it_own;
  logic [15:0]           it_fa;
  logic [15:0]           it_fr;
  logic                  it_fok;
  logic signed [FLOOR_W-1:0] it_flv;
  logic                  it_pok;
  logic [PCT_W-1:0]      it_pct;

  logic [CW-1:0]         entry_count;
  logic [AW-1:0]         chk_idx;
  logic                  found;
  logic [AW-1:0]         found_idx;
  rec_t                  found_rec;
  logic [STAT_W-1:0]     status;
  logic [CW-1:0]         n_ranked;
  logic                  have_best;
  rec_t                  best_rec;
  logic [CHAN_W-1:0]     best_chan;
  logic                  have_home;
  rec_t                  home_rec;

  logic [CHAN_W-1:0]     out_prop;
  logic [RCNT_W-1:0]     out_cnt;
  logic [STAT_W-1:0]     out_status;

  mem_ctl_t              mctl;
  logic [AW-1:0]         rd_addr;
  logic [AW-1:0]         wr_addr;
  rec_t                  wr_rec;
  rec_t                  rd_rec;

  logic                  accept;
  logic                  last_idx;
  logic [CHAN_W-1:0]     cur_chan;
  logic                  cur_ranked;
  logic                  table_full;
  logic [15:0]           diff;
  logic [BUSY_W-1:0]     busy_new;
  rec_t                  upd_rec;
  rec_t                  new_rec;
  logic                  out_free;
  logic [CHAN_W-1:0]     prop;
  logic [BUSY_W:0]       best_plus;

  function automatic logic blocked(rec_t r, logic [PCT_W-1:0] bp);
    return r.pct_seen && (r.pct >= bp);
  endfunction

  // True when entry a ranks strictly ahead of entry b.
  function automatic logic precedes(rec_t a, rec_t b, logic [PCT_W-1:0] bp);
    logic ab;
    logic bb;
    ab = blocked(a, bp);
    bb = blocked(b, bp);
    if (ab != bb) return !ab;
    if (ab && a.pct != b.pct) return a.pct < b.pct;
    if (a.busy != b.busy) return a.busy < b.busy;
    if (a.floor_seen != b.floor_seen) return a.floor_seen;
    if (a.floor_seen && a.floor_lvl != b.floor_lvl)
      return $signed(a.floor_lvl) < $signed(b.floor_lvl);
    return 1'b0;
  endfunction

  assign accept     = s_tvalid && s_tready;
  assign s_tready   = (state == ST_IDLE);
  assign last_idx   = (CW'(chk_idx) == entry_count - CW'(1));
  assign cur_chan   = (chk_idx == '0) ? home_channel : rd_rec.channel;
  assign cur_ranked = (rd_rec.visits >= rank_visits);
  assign table_full = (entry_count == CW'(MAX_ENTRIES));
  assign out_free   = !m_tvalid || m_tready;

  // Sample arithmetic and the entry as it will be written back.
  always_comb begin
    diff     = (it_cca > it_own) ? (it_cca - it_own) : 16'd0;
    busy_new = BUSY_W'(diff) + BUSY_W'(it_fa) + BUSY_W'(it_fr);
    upd_rec  = found_rec;
    if (found_rec.visits == '0 || busy_new > found_rec.busy) begin
      upd_rec.busy = busy_new;
    end
    if (found_rec.visits != VISIT_MAX) begin
      upd_rec.visits = found_rec.visits + VISIT_W'(1);
    end
    if (it_fok && (!found_rec.floor_seen ||
                   $signed(it_flv) > $signed(found_rec.floor_lvl))) begin
      upd_rec.floor_seen = 1'b1;
      upd_rec.floor_lvl  = it_flv;
    end
    if (it_pok && (!found_rec.pct_seen || it_pct > found_rec.pct)) begin
      upd_rec.pct_seen = 1'b1;
      upd_rec.pct      = it_pct;
    end
    new_rec         = '0;
    new_rec.channel = it_chan;
  end

  // Memory port drive.
  always_comb begin
    mctl.rd_en = 1'b0;
    mctl.wr_en = 1'b0;
    rd_addr    = chk_idx + AW'(1);
    wr_addr    = (it_cmd == CMD_SAMPLE) ? found_idx : entry_count[AW-1:0];
    wr_rec     = (it_cmd == CMD_SAMPLE) ? upd_rec : new_rec;
    unique case (state)
      ST_IDLE: begin
        mctl.rd_en = accept;
        rd_addr    = '0;
      end
      ST_FIND, ST_RANK: begin
        mctl.rd_en = 1'b1;
      end
      ST_RSTART: begin
        mctl.rd_en = 1'b1;
        rd_addr    = '0;
      end
      ST_UPDATE: begin
        mctl.wr_en = (it_cmd == CMD_SAMPLE) ? found : (!found && !table_full);
      end
      default: begin
      end
    endcase
  end

  // Home margin rule.
  always_comb begin
    best_plus = (BUSY_W+1)'(best_rec.busy) + (BUSY_W+1)'(leave_margin);
    if (!have_best) begin
      prop = home_channel;
    end else if (best_chan == home_channel || leave_margin == '0 || !have_home) begin
      prop = best_chan;
    end else if (blocked(home_rec, block_level) && !blocked(best_rec, block_level)) begin
      prop = best_chan;
    end else if (best_plus <= (BUSY_W+1)'(home_rec.busy)) begin
      prop = best_chan;
    end else begin
      prop = home_channel;
    end
  end

  cqr_store #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .ctl     (mctl),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .wr_rec  (wr_rec),
    .rd_rec  (rd_rec)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      home_channel <= '0;
      rank_visits  <= VISIT_W'(1);
      leave_margin <= '0;
      block_level  <= PCT_W'(100);
      entry_count  <= CW'(1);
      m_tvalid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_HOME_CHANNEL: home_channel <= cfg_data[CHAN_W-1:0];
          REG_RANK_VISITS:  rank_visits  <= cfg_data[VISIT_W-1:0];
          REG_LEAVE_MARGIN: leave_margin <= cfg_data[BUSY_W-1:0];
          REG_BLOCK_LEVEL:  block_level  <= cfg_data[PCT_W-1:0];
          default: begin
          end
        endcase
      end
      // The decision step raises valid itself when it hands over a beat.
      if (m_tvalid && m_tready && state != ST_DECIDE) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            it_cmd  <= s_tuser;
            it_chan <= s_tdata[7:0];
            it_cca  <= s_tdata[23:8];
            it_own  <= s_tdata[39:24];
            it_fa   <= s_tdata[55:40];
            it_fr   <= s_tdata[71:56];
            it_fok  <= s_tdata[72];
            it_flv  <= s_tdata[80:73];
            it_pok  <= s_tdata[81];
            it_pct  <= s_tdata[88:82];
            chk_idx <= '0;
            found   <= 1'b0;
            state   <= ST_FIND;
          end
        end
        ST_FIND: begin
          chk_idx <= chk_idx + AW'(1);
          if (cur_chan == it_chan) begin
            found     <= 1'b1;
            found_idx <= chk_idx;
            found_rec <= rd_rec;
            state     <= ST_UPDATE;
          end else if (last_idx) begin
            state <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          status <= ST_OK;
          if (it_cmd == CMD_REGISTER) begin
            if (found) begin
              status <= ST_DUPLICATE;
            end else if (table_full) begin
              status <= ST_FULL;
            end else begin
              entry_count <= entry_count + CW'(1);
            end
          end else if (!found) begin
            status <= ST_UNKNOWN;
          end
          state <= ST_RSTART;
        end
        ST_RSTART: begin
          chk_idx   <= '0;
          n_ranked  <= '0;
          have_best <= 1'b0;
          have_home <= 1'b0;
          state     <= ST_RANK;
        end
        ST_RANK: begin
          chk_idx <= chk_idx + AW'(1);
          if (cur_ranked) begin
            n_ranked <= n_ranked + CW'(1);
            if (!have_best || precedes(rd_rec, best_rec, block_level)) begin
              have_best <= 1'b1;
              best_rec  <= rd_rec;
              best_chan <= cur_chan;
            end
            if (cur_chan == home_channel &&
                (!have_home || precedes(rd_rec, home_rec, block_level))) begin
              have_home <= 1'b1;
              home_rec  <= rd_rec;
            end
          end
          if (last_idx) begin
            state <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          if (out_free) begin
            m_tvalid   <= 1'b1;
            out_prop   <= prop;
            out_cnt    <= RCNT_W'(n_ranked);
            out_status <= status;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_tdata = {3'b000, out_cnt, out_prop};
  assign m_tuser = out_status;

  a_entry_count_range: assert property (@(posedge clk) disable iff (rst)
    (entry_count >= CW'(1)) && (entry_count <= CW'(MAX_ENTRIES)))
    else $error("entry count out of range");

  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready)
    else $error("second beat taken while an item is at work");

  a_result_from_decide: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == ST_DECIDE))
    else $error("result raised outside the decision step");

endmodule

@@ tb/sv/proposal_checker.sv @@
`timescale 1ns / 100ps

module proposal_checker import cqr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [95:0]           s_tdata,
  input  logic                  s_tuser,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [15:0]           m_tdata,
  input  logic [STAT_W-1:0]     m_tuser,
  output int                    outstanding,
  output int                    errors
);

  localparam int SLOTS = MAX_ENTRIES_DEF;

  typedef struct {
    int                  seq;
    logic [CHAN_W-1:0]   chan;
    logic [RCNT_W-1:0]   ranked;
    logic [STAT_W-1:0]   status;
  } proposal_t;

  proposal_t expected_proposals[$];

  // Our own copy of the register file and the channel table.
  logic [CHAN_W-1:0]         home_ch;
  logic [VISIT_W-1:0]        min_visits;
  logic [BUSY_W-1:0]         margin;
  logic [PCT_W-1:0]          block_pct;

  logic [CHAN_W-1:0]         slot_chan  [SLOTS];
  int                        n_used;
  logic [BUSY_W-1:0]         busy_worst [SLOTS];
  logic [VISIT_W-1:0]        visits     [SLOTS];
  logic                      floor_vld  [SLOTS];
  logic signed [FLOOR_W-1:0] floor_top  [SLOTS];
  logic                      pct_vld    [SLOTS];
  logic [PCT_W-1:0]          pct_worst  [SLOTS];

  int items_in;

  initial begin
    errors = 0;
    outstanding = 0;
  end

  task automatic note_error(input string msg);
    errors++;
    $display("ERROR at %0t: %s", $time, msg);
  endtask

  task automatic clear_table();
    home_ch    = '0;
    min_visits = 8'd1;
    margin     = '0;
    block_pct  = 7'd100;
    n_used     = 1;
    for (int i = 0; i < SLOTS; i++) begin
      slot_chan[i]  = '0;
      busy_worst[i] = '0;
      visits[i]     = '0;
      floor_vld[i]  = 1'b0;
      floor_top[i]  = '0;
      pct_vld[i]    = 1'b0;
      pct_worst[i]  = '0;
    end
  endtask

  // Entry zero always answers to the current home channel.
  function automatic logic [CHAN_W-1:0] chan_at(int i);
    return (i == 0) ? home_ch : slot_chan[i];
  endfunction

  function automatic bit blocked_at(int i);
    return pct_vld[i] && (pct_worst[i] >= block_pct);
  endfunction

  // True when entry a ranks strictly ahead of entry b.
  function automatic bit ahead_of(int a, int b);
    bit ba;
    bit bb;
    ba = blocked_at(a);
    bb = blocked_at(b);
    if (ba != bb) return !ba;
    if (ba && pct_worst[a] != pct_worst[b]) return pct_worst[a] < pct_worst[b];
    if (busy_worst[a] != busy_worst[b]) return busy_worst[a] < busy_worst[b];
    if (floor_vld[a] != floor_vld[b]) return floor_vld[a];
    if (floor_vld[a] && floor_top[a] != floor_top[b]) return floor_top[a] < floor_top[b];
    return 1'b0;
  endfunction

  function automatic int find_slot(logic [CHAN_W-1:0] ch);
    for (int i = 0; i < n_used; i++)
      if (chan_at(i) == ch) return i;
    return -1;
  endfunction

  task automatic rank_channels(output logic [CHAN_W-1:0] pick, output int n);
    int best;
    int home;
    int unsigned need;
    best = -1;
    home = -1;
    n = 0;
    for (int i = 0; i < n_used; i++) begin
      if (visits[i] < min_visits) continue;
      n++;
      if (best < 0 || ahead_of(i, best)) best = i;
      if (chan_at(i) == home_ch && (home < 0 || ahead_of(i, home))) home = i;
    end
    if (best < 0) begin
      pick = home_ch;
    end else if (chan_at(best) == home_ch || margin == '0 || home < 0) begin
      pick = chan_at(best);
    end else if (blocked_at(home) && !blocked_at(best)) begin
      pick = chan_at(best);
    end else begin
      // Leaving home needs the full margin of busy advantage.
      need = 32'(busy_worst[best]) + 32'(margin);
      pick = (need <= 32'(busy_worst[home])) ? chan_at(best) : home_ch;
    end
  endtask

  task automatic step_channel_table(input logic cmd, input logic [95:0] d,
                                    output proposal_t r);
    logic [CHAN_W-1:0]         ch;
    logic [CHAN_W-1:0]         pick;
    logic signed [FLOOR_W-1:0] flv;
    logic [PCT_W-1:0]          pct;
    int                        idx;
    int                        n;
    int unsigned               cca;
    int unsigned               own;
    int unsigned               load;
    ch = d[7:0];
    idx = find_slot(ch);
    r.status = ST_OK;
    if (cmd == CMD_REGISTER) begin
      if (idx >= 0) begin
        r.status = ST_DUPLICATE;
      end else if (n_used >= SLOTS) begin
        r.status = ST_FULL;
      end else begin
        slot_chan[n_used]  = ch;
        busy_worst[n_used] = '0;
        visits[n_used]     = '0;
        floor_vld[n_used]  = 1'b0;
        floor_top[n_used]  = '0;
        pct_vld[n_used]    = 1'b0;
        pct_worst[n_used]  = '0;
        n_used++;
      end
    end else if (idx < 0) begin
      r.status = ST_UNKNOWN;
    end else begin
      cca  = 32'(d[23:8]);
      own  = 32'(d[39:24]);
      load = ((cca > own) ? cca - own : 32'd0) + 32'(d[55:40]) + 32'(d[71:56]);
      flv  = d[80:73];
      pct  = d[88:82];
      if (visits[idx] == '0 || load > 32'(busy_worst[idx]))
        busy_worst[idx] = load[BUSY_W-1:0];
      if (visits[idx] != VISIT_MAX) visits[idx]++;
      if (d[72] && (!floor_vld[idx] || flv > floor_top[idx])) begin
        floor_vld[idx] = 1'b1;
        floor_top[idx] = flv;
      end
      if (d[81] && (!pct_vld[idx] || pct > pct_worst[idx])) begin
        pct_vld[idx]   = 1'b1;
        pct_worst[idx] = pct;
      end
    end
    rank_channels(pick, n);
    r.chan   = pick;
    r.ranked = n[RCNT_W-1:0];
  endtask

  always @(posedge clk) begin
    proposal_t want;
    proposal_t fresh;
    if (rst) begin
      clear_table();
      expected_proposals.delete();
      items_in = 0;
      outstanding <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_HOME_CHANNEL: home_ch    = cfg_data[CHAN_W-1:0];
          REG_RANK_VISITS:  min_visits = cfg_data[VISIT_W-1:0];
          REG_LEAVE_MARGIN: margin     = cfg_data[BUSY_W-1:0];
          REG_BLOCK_LEVEL:  block_pct  = cfg_data[PCT_W-1:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        if (expected_proposals.size() == 0) begin
          note_error($sformatf("result beat with nothing expected (channel %0d)",
                               m_tdata[7:0]));
        end else begin
          want = expected_proposals.pop_front();
          if (m_tdata[7:0] !== want.chan)
            note_error($sformatf("item %0d proposed_channel %0d, expected %0d",
                                 want.seq, m_tdata[7:0], want.chan));
          if (m_tdata[12:8] !== want.ranked)
            note_error($sformatf("item %0d ranked_count %0d, expected %0d",
                                 want.seq, m_tdata[12:8], want.ranked));
          if (m_tuser !== want.status)
            note_error($sformatf("item %0d status %0d, expected %0d",
                                 want.seq, m_tuser, want.status));
        end
      end
      if (s_tvalid && s_tready) begin
        step_channel_table(s_tuser, s_tdata, fresh);
        fresh.seq = items_in;
        items_in++;
        expected_proposals = {expected_proposals, fresh};
      end
      outstanding <= expected_proposals.size();
    end
  end

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import cqr_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 4'd15;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 194;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [95:0]           s_tdata;
  logic                  s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [15:0]           m_tdata;
  logic [STAT_W-1:0]     m_tuser;
  int                    outstanding;
  int                    errors;

  int gap_pct;
  int stall_pct;
  logic [CHAN_W-1:0] home_now;
  logic [CHAN_W-1:0] known_ch[$];

  channel_quality_ranker DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  proposal_checker proposal_check (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .outstanding (outstanding),
    .errors      (errors)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  initial begin
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Holds the beat until it is taken; random idle cycles go in front of it.
  task automatic send_beat(input logic cmd, input logic [95:0] payload);
    while ($urandom_range(99) < gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= payload;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic send_item(input logic cmd, input logic [7:0] ch,
                           input logic [15:0] cca, own, fa, fr,
                           input logic fok, input logic [7:0] flv,
                           input logic pok, input logic [6:0] pct);
    if (cmd == CMD_REGISTER) known_ch = {known_ch, ch};
    send_beat(cmd, {7'd0, pct, pok, flv, fok, fr, fa, own, cca, ch});
  endtask

  task automatic send_candidate(input logic [7:0] ch);
    send_item(CMD_REGISTER, ch, '0, '0, '0, '0, 1'b0, '0, 1'b0, '0);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_random_item();
    logic              cmd;
    logic [7:0]        ch;
    logic [15:0]       cca;
    logic [15:0]       own;
    logic [15:0]       fa;
    logic [15:0]       fr;
    int                sel;
    int                pr;
    sel = $urandom_range(99);
    cmd = (sel < 12) ? CMD_REGISTER : CMD_SAMPLE;
    sel = $urandom_range(99);
    if (cmd == CMD_REGISTER)
      ch = (sel < 50 || known_ch.size() == 0) ? 8'($urandom_range(255))
                                              : known_ch[$urandom_range(known_ch.size() - 1)];
    else if (sel < 65 && known_ch.size() != 0)
      ch = known_ch[$urandom_range(known_ch.size() - 1)];
    else if (sel < 80)
      ch = home_now;
    else
      ch = 8'($urandom_range(255));
    // Busy is kept as a worst value, so full-scale counts are kept rare.
    if ($urandom_range(99) < 3) begin
      cca = 16'($urandom_range(65535));
      own = 16'($urandom_range(65535));
      fa  = 16'($urandom_range(65535));
      fr  = 16'($urandom_range(65535));
    end else begin
      cca = 16'($urandom_range(4000));
      own = 16'($urandom_range(2000));
      fa  = 16'($urandom_range(500));
      fr  = 16'($urandom_range(500));
    end
    pr = $urandom_range(99);
    send_item(cmd, ch, cca, own, fa, fr, 1'($urandom_range(1)), 8'($urandom_range(255)),
              ($urandom_range(99) < 25),
              (pr < 80) ? 7'($urandom_range(60)) :
              (pr < 95) ? 7'($urandom_range(100, 61)) : 7'($urandom_range(127, 101)));
  endtask

  initial begin
    logic [CHAN_W-1:0] rounds;
    logic [BUSY_W-1:0] margin_val;
    logic [PCT_W-1:0]  blk;
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = CMD_REGISTER;
    m_tready  = 1'b0;
    gap_pct   = 0;
    stall_pct = 0;
    home_now  = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, register defaults first.
    send_item(CMD_SAMPLE, 8'd0, '0, '0, '0, '0, 1'b0, '0, 1'b0, '0);
    send_candidate(8'd255);
    send_candidate(8'd255);
    send_candidate(8'd0);
    send_item(CMD_SAMPLE, 8'd77, 16'hFFFF, '0, '0, '0, 1'b1, 8'h80, 1'b1, 7'd50);
    send_item(CMD_SAMPLE, 8'd255, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF,
              1'b1, 8'h80, 1'b1, 7'd100);
    // Own count above the busy count clamps to zero; percent above 100 is kept.
    send_item(CMD_SAMPLE, 8'd255, 16'h0001, 16'hFFFF, '0, '0, 1'b1, 8'h7F, 1'b1, 7'd127);
    send_item(CMD_SAMPLE, 8'd0, 16'd10, 16'd3, 16'd1, 16'd1, 1'b0, 8'h7F, 1'b0, 7'd127);
    wait_idle();

    // Home moves onto an existing candidate; unvisited entries become ranked.
    set_reg(REG_RANK_VISITS, 18'd0);
    set_reg(REG_LEAVE_MARGIN, 18'd196605);
    set_reg(REG_BLOCK_LEVEL, 18'd0);
    set_reg(REG_HOME_CHANNEL, 18'd255);
    set_reg(REG_SPARE, 18'h3FFFF);
    home_now = 8'd255;
    send_item(CMD_SAMPLE, 8'd255, 16'd20, 16'd5, 16'd2, 16'd3, 1'b1, 8'hF0, 1'b1, 7'd0);
    send_candidate(8'd255);
    // Fill the table; the last candidate finds it full.
    for (int c = 1; c <= 15; c++) send_candidate(8'(c));
    wait_idle();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 57; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 57; end
        default: begin gap_pct = 35; stall_pct = 35; end
      endcase
      if (ph == 2)
        home_now = 8'd0;
      else if (ph == 5)
        home_now = 8'd255;
      else if ($urandom_range(1) != 0)
        home_now = known_ch[$urandom_range(known_ch.size() - 1)];
      else
        home_now = 8'($urandom_range(255));
      rounds = (ph == 1) ? 8'd0 : (ph == 7) ? 8'd255 : 8'($urandom_range(6, 1));
      if (ph == 0)
        margin_val = '0;
      else if (ph == 4)
        margin_val = 18'd196605;
      else if ($urandom_range(1) != 0)
        margin_val = 18'($urandom_range(3000, 1));
      else
        margin_val = 18'($urandom_range(196605));
      blk = (ph == 3) ? 7'd0 : (ph == 6) ? 7'd100 : 7'($urandom_range(100));
      set_reg(REG_HOME_CHANNEL, {10'd0, home_now});
      set_reg(REG_RANK_VISITS, {10'd0, rounds});
      set_reg(REG_LEAVE_MARGIN, margin_val);
      set_reg(REG_BLOCK_LEVEL, {11'd0, blk});
      if (ph == 3) set_reg(REG_SPARE, 18'($urandom_range(262143)));
      repeat (PHASE_ITEMS) send_random_item();
      wait_idle();
    end

    repeat (40) @(posedge clk);
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
